FILE: rtl/core/wppf_pkg.sv
// Package for the prominence peak finder: widths, register map and shared types.
// No dependencies; the register file, judge, sequencer, top level and testbench import it.
package wppf_pkg;

    localparam int HistoryDepth = 512;
    localparam int HistAw       = $clog2(HistoryDepth);
    localparam int SampleBits   = 16;
    localparam int MaxLength    = 65536;
    localparam int CountBits    = $clog2(MaxLength);
    localparam int ResultCap    = 64;

    localparam logic [CountBits-1:0] CountMax = CountBits'(MaxLength - 1);

    localparam int AddrBits = 5;

    typedef enum logic [2:0] {
        REG_LEFT_WIDTH   = 3'd0,
        REG_RIGHT_WIDTH  = 3'd1,
        REG_MONO_SPAN    = 3'd2,
        REG_LEFT_SCAN    = 3'd3,
        REG_RIGHT_SCAN   = 3'd4,
        REG_MIN_PROM     = 3'd5,
        REG_BASE_LOWER   = 3'd6,
        REG_UNUSED       = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic [4:0]             left_width;
        logic [4:0]             right_width;
        logic [3:0]             monotonic_span;
        logic [8:0]             left_scan_limit;
        logic [5:0]             right_scan_limit;
        logic [15:0]            min_prominence;
        logic signed [15:0]     base_lower_bound;
    } cfg_t;

    // Request from the sequencer to the judge unit, and its answer.
    typedef struct packed {
        logic                   start;
        logic [CountBits-1:0]   cand;
        logic [CountBits:0]     n;
    } judge_req_t;

    typedef struct packed {
        logic                   done;
        logic                   accept;
        logic [15:0]            prom;
    } judge_rsp_t;

endpackage

FILE: rtl/core/wppf_stream_if.sv
// Valid/ready stream interfaces carrying payloads of parameter-free types.
// Depends on nothing; the payload types are fixed inside each interface.
interface wppf_in_if;
    logic                         valid;
    logic                         ready;
    logic signed [15:0]           sample;
    logic                         last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

interface wppf_out_if;
    logic        valid;
    logic        ready;
    logic        is_peak;
    logic [15:0] peak_index;
    logic [15:0] prominence;
    logic        end_of_waveform;

    modport source (output valid, output is_peak, output peak_index, output prominence,
                    output end_of_waveform, input ready);
    modport sink   (input valid, input is_peak, input peak_index, input prominence,
                    input end_of_waveform, output ready);
endinterface

FILE: rtl/core/wppf_cfg_regs.sv
// APB-style register file for the peak finder configuration.
// Depends on wppf_pkg.
module wppf_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wppf_pkg::AddrBits-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output wppf_pkg::cfg_t              cfg
);
    import wppf_pkg::*;

    cfg_t       cfg_reg;
    reg_index_t idx;
    logic       wr_en;

    assign idx    = reg_index_t'(paddr[AddrBits-1:2]);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left_width       <= 5'd10;
            cfg_reg.right_width      <= 5'd10;
            cfg_reg.monotonic_span   <= 4'd0;
            cfg_reg.left_scan_limit  <= 9'd200;
            cfg_reg.right_scan_limit <= 6'd50;
            cfg_reg.min_prominence   <= 16'd21;
            cfg_reg.base_lower_bound <= 16'sh8000;
        end
        else if (wr_en && paddr[1:0] == 2'b00)
        begin
            unique case (idx)
                REG_LEFT_WIDTH:  cfg_reg.left_width       <= pwdata[4:0];
                REG_RIGHT_WIDTH: cfg_reg.right_width      <= pwdata[4:0];
                REG_MONO_SPAN:   cfg_reg.monotonic_span   <= pwdata[3:0];
                REG_LEFT_SCAN:   cfg_reg.left_scan_limit  <= pwdata[8:0];
                REG_RIGHT_SCAN:  cfg_reg.right_scan_limit <= pwdata[5:0];
                REG_MIN_PROM:    cfg_reg.min_prominence   <= pwdata[15:0];
                REG_BASE_LOWER:  cfg_reg.base_lower_bound <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[1:0] == 2'b00)
        begin
            unique case (idx)
                REG_LEFT_WIDTH:  prdata = {27'd0, cfg_reg.left_width};
                REG_RIGHT_WIDTH: prdata = {27'd0, cfg_reg.right_width};
                REG_MONO_SPAN:   prdata = {28'd0, cfg_reg.monotonic_span};
                REG_LEFT_SCAN:   prdata = {23'd0, cfg_reg.left_scan_limit};
                REG_RIGHT_SCAN:  prdata = {26'd0, cfg_reg.right_scan_limit};
                REG_MIN_PROM:    prdata = {16'd0, cfg_reg.min_prominence};
                REG_BASE_LOWER:  prdata = {16'd0, cfg_reg.base_lower_bound};
                default:         prdata = '0;
            endcase
        end
    end
endmodule

FILE: rtl/core/wppf_judge.sv
// Candidate judge: walks the history ring through its single read port, one candidate
// at a time, under a small sequencer. Owns the history memory. Depends on wppf_pkg.
module wppf_judge (
    input  logic                            clk,
    input  logic                            rst_n,
    input  wppf_pkg::cfg_t                  cfg,
    input  logic                            wr_en,
    input  logic [wppf_pkg::HistAw-1:0]     wr_addr,
    input  logic signed [15:0]              wr_data,
    input  wppf_pkg::judge_req_t            req,
    output wppf_pkg::judge_rsp_t            rsp
);
    import wppf_pkg::*;

    typedef enum logic [3:0] {
        J_IDLE, J_PEAK, J_WIN, J_MRISE, J_MFALL, J_LWALK, J_LMIN, J_RWALK, J_DONE
    } jstate_t;

    // Signed 18-bit index space covers negative offsets and n up to 2^16.
    typedef logic signed [17:0] sidx_t;

    logic signed [15:0] mem [HistoryDepth];
    logic signed [15:0] rd_data;
    logic [HistAw-1:0]  rd_addr;

    jstate_t            st_reg, st_next;
    sidx_t              c_reg, c_next;
    sidx_t              n_reg, n_next;
    sidx_t              j_reg, j_next;
    sidx_t              li_reg, li_next;
    logic               pend_reg, pend_next;
    logic signed [15:0] h_reg, h_next;
    logic signed [15:0] prev_reg, prev_next;
    logic signed [15:0] lmin_reg, lmin_next;
    logic signed [15:0] rmin_reg, rmin_next;
    judge_rsp_t         rsp_reg, rsp_next;

    sidx_t w, lw, rw, d, lsl, rsl;
    logic [15:0]        prom_full;
    logic [15:0]        prom_eff;
    logic signed [15:0] base;

    assign lw  = sidx_t'(cfg.left_width);
    assign rw  = sidx_t'(cfg.right_width);
    assign w   = (lw > rw) ? lw : rw;
    assign d   = sidx_t'(cfg.monotonic_span);
    assign lsl = sidx_t'(cfg.left_scan_limit);
    assign rsl = sidx_t'(cfg.right_scan_limit);
    assign rsp = rsp_reg;

    // Memory: one write port for the stream, one registered read port for the judge.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

    // The base never exceeds the peak, so the difference always fits 16 unsigned bits.
    // A base below the lower bound counts as a prominence of zero.
    assign base      = (lmin_reg < rmin_reg) ? lmin_reg : rmin_reg;
    assign prom_full = h_reg - base;
    assign prom_eff  = (base < cfg.base_lower_bound) ? 16'd0 : prom_full;

    always_comb
    begin
        st_next   = st_reg;
        c_next    = c_reg;
        n_next    = n_reg;
        j_next    = j_reg;
        li_next   = li_reg;
        pend_next = 1'b0;
        h_next    = h_reg;
        prev_next = prev_reg;
        lmin_next = lmin_reg;
        rmin_next = rmin_reg;
        rsp_next  = '0;
        rd_addr   = j_reg[HistAw-1:0];

        // pend_reg marks that rd_data holds the entry addressed last cycle.
        unique case (st_reg)
            J_IDLE:
            begin
                if (req.start)
                begin
                    c_next = sidx_t'(req.cand);
                    n_next = sidx_t'(req.n);
                    if (sidx_t'(req.cand) < w || sidx_t'(req.cand) + w >= sidx_t'(req.n))
                        st_next = J_DONE;
                    else
                    begin
                        j_next    = sidx_t'(req.cand);
                        st_next   = J_PEAK;
                    end
                end
            end
            J_PEAK:
            begin
                if (!pend_reg)
                begin
                    pend_next = 1'b1;
                    j_next    = c_reg - lw;
                end
                else
                begin
                    h_next    = rd_data;
                    rd_addr   = j_reg[HistAw-1:0];
                    pend_next = 1'b1;
                    j_next    = j_reg + 18'sd1;
                    st_next   = J_WIN;
                end
            end
            J_WIN:
            begin
                // rd_data holds entry j_reg-1.
                pend_next = 1'b1;
                j_next    = j_reg + 18'sd1;
                if (j_reg - 18'sd1 != c_reg && rd_data > h_reg)
                    st_next = J_DONE;
                else if (j_reg - 18'sd1 == c_reg + rw)
                begin
                    pend_next = 1'b0;
                    if (d != 18'sd0)
                    begin
                        if (c_reg < d || c_reg + d + 18'sd1 >= n_reg)
                            st_next = J_DONE;
                        else
                        begin
                            j_next  = c_reg - d;
                            st_next = J_MRISE;
                        end
                    end
                    else
                    begin
                        li_next = c_reg - 18'sd1;
                        j_next  = c_reg - 18'sd1;
                        st_next = J_LWALK;
                    end
                end
            end
            J_MRISE:
            begin
                // Reads j from c-d to c; each new entry must not fall below previous.
                pend_next = 1'b1;
                j_next    = j_reg + 18'sd1;
                if (pend_reg)
                begin
                    prev_next = rd_data;
                    if (j_reg - 18'sd1 != c_reg - d && prev_reg > rd_data)
                        st_next = J_DONE;
                    else if (j_reg - 18'sd1 == c_reg)
                    begin
                        pend_next = 1'b0;
                        j_next    = c_reg + 18'sd1;
                        st_next   = J_MFALL;
                    end
                end
            end
            J_MFALL:
            begin
                pend_next = 1'b1;
                j_next    = j_reg + 18'sd1;
                if (pend_reg)
                begin
                    prev_next = rd_data;
                    if (j_reg - 18'sd1 != c_reg + 18'sd1 && prev_reg < rd_data)
                        st_next = J_DONE;
                    else if (j_reg - 18'sd1 == c_reg + d + 18'sd1)
                    begin
                        pend_next = 1'b0;
                        li_next   = c_reg - 18'sd1;
                        j_next    = c_reg - 18'sd1;
                        st_next   = J_LWALK;
                    end
                end
            end
            J_LWALK:
            begin
                // Walk li left while below the peak, above zero and in the scan limit.
                lmin_next = h_reg;
                if (c_reg == 18'sd0)
                begin
                    j_next  = c_reg + 18'sd1;
                    rmin_next = h_reg;
                    st_next = J_RWALK;
                end
                else if (!pend_reg)
                    pend_next = 1'b1;
                else if (li_reg > 18'sd0 && rd_data < h_reg && li_reg + lsl >= c_reg)
                begin
                    li_next   = li_reg - 18'sd1;
                    j_next    = li_reg - 18'sd1;
                    pend_next = 1'b0;
                end
                else
                begin
                    j_next  = li_reg;
                    st_next = J_LMIN;
                end
            end
            J_LMIN:
            begin
                pend_next = 1'b1;
                j_next    = j_reg + 18'sd1;
                if (pend_reg)
                begin
                    if (rd_data < lmin_reg && rd_data != 16'sd0)
                        lmin_next = rd_data;
                    if (j_reg == c_reg)
                    begin
                        pend_next = 1'b0;
                        rmin_next = h_reg;
                        j_next    = c_reg + 18'sd1;
                        st_next   = J_RWALK;
                    end
                end
                else if (j_reg == c_reg)
                begin
                    rmin_next = h_reg;
                    j_next    = c_reg + 18'sd1;
                    st_next   = J_RWALK;
                end
            end
            J_RWALK:
            begin
                // Walk and take the minimum at once until the bound, n or a sample >= h.
                if (j_reg >= n_reg || j_reg > c_reg + rsl)
                    st_next = J_DONE;
                else if (!pend_reg)
                    pend_next = 1'b1;
                else if (rd_data < h_reg)
                begin
                    if (rd_data < rmin_reg && rd_data != 16'sd0)
                        rmin_next = rd_data;
                    j_next = j_reg + 18'sd1;
                end
                else
                    st_next = J_DONE;
                if (st_next == J_DONE)
                begin
                    st_next       = J_IDLE;
                    rsp_next.done = 1'b1;
                    if (prom_eff >= cfg.min_prominence)
                    begin
                        rsp_next.accept = 1'b1;
                        rsp_next.prom   = prom_eff;
                    end
                end
            end
            J_DONE:
            begin
                rsp_next.done = 1'b1;
                st_next       = J_IDLE;
            end
            default: st_next = J_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= J_IDLE;
            pend_reg <= 1'b0;
            rsp_reg  <= '0;
        end
        else
        begin
            st_reg   <= st_next;
            pend_reg <= pend_next;
            rsp_reg  <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg    <= c_next;
        n_reg    <= n_next;
        j_reg    <= j_next;
        li_reg   <= li_next;
        h_reg    <= h_next;
        prev_reg <= prev_next;
        lmin_reg <= lmin_next;
        rmin_reg <= rmin_next;
    end
endmodule

FILE: rtl/core/wppf_seq.sv
// Stream sequencer: accepts samples, writes the ring, issues candidates to the
// judge and hands results to the output register. Depends on wppf_pkg.
module wppf_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  wppf_pkg::cfg_t              cfg,
    wppf_in_if.sink                     in_ch,
    wppf_out_if.source                  out_ch,
    output logic                        wr_en,
    output logic [wppf_pkg::HistAw-1:0] wr_addr,
    output logic signed [15:0]          wr_data,
    output wppf_pkg::judge_req_t        req,
    input  wppf_pkg::judge_rsp_t        rsp
);
    import wppf_pkg::*;

    typedef enum logic [2:0] {
        S_IN, S_ONE, S_WAIT1, S_FLUSH, S_WAITF, S_EMIT
    } sstate_t;

    typedef logic [CountBits:0] cnt_t;

    sstate_t            st_reg;
    cnt_t               cnt_reg;
    cnt_t               c_reg;
    logic [6:0]         k_reg;
    logic               flush_reg;
    logic               have_reg;
    logic [15:0]        hidx_reg, hprom_reg;
    logic [15:0]        nidx_reg, nprom_reg;
    logic               ov_reg;
    logic [15:0]        oidx_reg, oprom_reg;
    logic               opeak_reg, oend_reg;

    cnt_t   a, s, lo;
    logic   acc, store, flush_end, ov_load;

    always_comb
    begin
        a = cnt_t'(cfg.left_width > cfg.right_width ? cfg.left_width : cfg.right_width);
        if (cnt_t'(cfg.monotonic_span) + 1'b1 > a)
            a = cnt_t'(cfg.monotonic_span) + 1'b1;
        if (cnt_t'(cfg.right_scan_limit) + 1'b1 > a)
            a = cnt_t'(cfg.right_scan_limit) + 1'b1;
    end

    assign s         = cnt_reg;
    assign store     = cnt_reg < cnt_t'(CountMax);
    assign lo        = (s >= a) ? s - a : '0;
    assign acc       = in_ch.valid && in_ch.ready;
    assign flush_end = (c_reg >= cnt_reg) || (k_reg == 7'(ResultCap));

    assign in_ch.ready = (st_reg == S_IN) && !ov_reg;
    assign wr_en       = acc && store;
    assign wr_addr     = s[HistAw-1:0];
    assign wr_data     = in_ch.sample;

    assign out_ch.valid           = ov_reg;
    assign out_ch.is_peak         = opeak_reg;
    assign out_ch.peak_index      = oidx_reg;
    assign out_ch.prominence      = oprom_reg;
    assign out_ch.end_of_waveform = oend_reg;

    always_comb
    begin
        req.start = (st_reg == S_ONE) || (st_reg == S_FLUSH && !flush_end);
        req.cand  = c_reg[CountBits-1:0];
        req.n     = cnt_reg;
    end

    // The output register is loaded when a result is ready and it is free or leaving.
    always_comb
    begin
        ov_load = 1'b0;
        if (st_reg == S_WAIT1 && rsp.done && rsp.accept)
            ov_load = 1'b1;
        if (st_reg == S_EMIT && (!ov_reg || out_ch.ready))
            ov_load = 1'b1;
    end

    // During the flush, results are held one behind so the final one can carry the end mark.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_IN;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
            have_reg  <= 1'b0;
            flush_reg <= 1'b0;
            k_reg     <= '0;
            c_reg     <= '0;
            hidx_reg  <= '0;
            hprom_reg <= '0;
            nidx_reg  <= '0;
            nprom_reg <= '0;
            oidx_reg  <= '0;
            oprom_reg <= '0;
            opeak_reg <= 1'b0;
            oend_reg  <= 1'b0;
        end
        else
        begin
            if (ov_load)
                ov_reg <= 1'b1;
            else if (ov_reg && out_ch.ready)
                ov_reg <= 1'b0;
            unique case (st_reg)
                S_IN:
                begin
                    if (acc)
                    begin
                        if (store)
                            cnt_reg <= cnt_reg + 1'b1;
                        k_reg <= '0;
                        if (in_ch.last)
                        begin
                            c_reg   <= lo;
                            st_reg  <= S_FLUSH;
                        end
                        else if (store && s >= a)
                        begin
                            c_reg  <= s - a;
                            st_reg <= S_ONE;
                        end
                    end
                end
                S_ONE:   st_reg <= S_WAIT1;
                S_WAIT1:
                begin
                    if (rsp.done)
                    begin
                        if (rsp.accept)
                        begin
                            opeak_reg <= 1'b1;
                            oidx_reg  <= c_reg[15:0];
                            oprom_reg <= rsp.prom;
                            oend_reg  <= 1'b0;
                        end
                        st_reg <= S_IN;
                    end
                end
                S_FLUSH:
                begin
                    if (flush_end)
                        st_reg <= S_EMIT;
                    else
                        st_reg <= S_WAITF;
                end
                S_WAITF:
                begin
                    if (rsp.done)
                    begin
                        c_reg <= c_reg + 1'b1;
                        if (rsp.accept)
                        begin
                            k_reg <= k_reg + 1'b1;
                            if (have_reg)
                            begin
                                // The held peak must leave before the new one is held.
                                nidx_reg  <= c_reg[15:0];
                                nprom_reg <= rsp.prom;
                                flush_reg <= 1'b1;
                                st_reg    <= S_EMIT;
                            end
                            else
                            begin
                                have_reg  <= 1'b1;
                                hidx_reg  <= c_reg[15:0];
                                hprom_reg <= rsp.prom;
                                st_reg    <= S_FLUSH;
                            end
                        end
                        else
                            st_reg <= S_FLUSH;
                    end
                end
                S_EMIT:
                begin
                    if (!ov_reg || out_ch.ready)
                    begin
                        if (flush_reg)
                        begin
                            // A held peak is released; the new one takes its place.
                            opeak_reg <= 1'b1;
                            oidx_reg  <= hidx_reg;
                            oprom_reg <= hprom_reg;
                            oend_reg  <= 1'b0;
                            hidx_reg  <= nidx_reg;
                            hprom_reg <= nprom_reg;
                            flush_reg <= 1'b0;
                            st_reg    <= S_FLUSH;
                        end
                        else
                        begin
                            opeak_reg <= have_reg;
                            oidx_reg  <= have_reg ? hidx_reg : 16'd0;
                            oprom_reg <= have_reg ? hprom_reg : 16'd0;
                            oend_reg  <= 1'b1;
                            have_reg  <= 1'b0;
                            cnt_reg   <= '0;
                            st_reg    <= S_IN;
                        end
                    end
                end
                default: st_reg <= S_IN;
            endcase
        end
    end
endmodule

FILE: rtl/core/waveform_prominence_peak_finder_core.sv
// Top level of the streaming prominence peak finder.
// Depends on wppf_pkg, wppf_stream_if, wppf_cfg_regs, wppf_seq and wppf_judge.
//
// Use: samples enter on the in_ch channel, one transfer per sample, with last
// set on the final sample of a waveform. Results leave on out_ch: each accepted
// peak gives one transfer with its index and prominence, and the final transfer
// of a waveform carries end_of_waveform (empty if the flush found no peak).
// Registers are written through the APB-style port between waveforms.
//
// Flow: each sample is stored in the 512-entry history ring and then the
// candidate the delay behind it, if any (the largest of the two widths, span + 1
// and right scan + 1), is judged by the judge unit, which reads the ring through
// a single read port; samples are not taken meanwhile. Samples that judge no
// candidate are taken back to back while the output register is free. The last
// sample judges the waiting candidates in turn, stopping after 64 accepted
// peaks. The ring read port is what sets the rate.
//
// Reset clears the sample counter, the sequencers and the registers to their
// defaults; the ring needs no clearing. When the receiver stalls, the result
// waits in the output register and no further sample is taken until it leaves.
module waveform_prominence_peak_finder_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wppf_pkg::AddrBits-1:0]   paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    wppf_in_if.sink                         in_ch,
    wppf_out_if.source                      out_ch
);
    import wppf_pkg::*;

    cfg_t               cfg;
    logic               wr_en;
    logic [HistAw-1:0]  wr_addr;
    logic signed [15:0] wr_data;
    judge_req_t         req;
    judge_rsp_t         rsp;

    wppf_cfg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The sequencer owns the stream side and the sample counter.
    wppf_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .req     (req),
        .rsp     (rsp)
    );

    // The judge holds the ring and does all the scanning.
    wppf_judge u_judge (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .req     (req),
        .rsp     (rsp)
    );
endmodule

FILE: rtl/core/wppf_checker.sv
// Port-level checker for the peak finder, bound to the top level.
// Depends on wppf_stream_if through the top level's interface ports.
module wppf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_is_peak,
    input logic        out_end,
    input logic [15:0] out_prom
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_no_take_while_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("sample taken while a result waits");

    a_empty_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_is_peak |-> out_end && out_prom == 16'd0)
        else $error("non-peak result is not an empty end");

    a_payload_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_prom) && $stable(out_is_peak)
                                    && $stable(out_end))
        else $error("result changed while stalled");
endmodule

bind waveform_prominence_peak_finder_core wppf_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_is_peak (out_ch.is_peak),
    .out_end     (out_ch.end_of_waveform),
    .out_prom    (out_ch.prominence)
);

FILE: tb/tb_top.sv
// Self-checking testbench for waveform_prominence_peak_finder_core.
// Depends on wppf_pkg and on the wppf_in_if / wppf_out_if stream interfaces.
// A scoreboard class predicts the peak results and checks each output transfer.

import wppf_pkg::*;

typedef struct {
    logic        is_peak;
    logic [15:0] peak_index;
    logic [15:0] prominence;
    logic        end_of_waveform;
} peak_result_t;

class peak_scoreboard;
    int            ring [HistoryDepth];
    int unsigned   count;
    int unsigned   lw, rw, span, lscan, rscan, min_prom;
    int            lower_bound;
    peak_result_t  expected_peaks [$];
    int            mismatches;

    function new();
        count       = 0;
        lw          = 10;
        rw          = 10;
        span        = 0;
        lscan       = 200;
        rscan       = 50;
        min_prom    = 21;
        lower_bound = -32768;
        mismatches  = 0;
        foreach (ring[i]) ring[i] = 0;
    endfunction

    task report(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        mismatches++;
    endtask

    function void set_reg(reg_index_t idx, logic [31:0] value);
        case (idx)
            REG_LEFT_WIDTH:  lw          = value[4:0];
            REG_RIGHT_WIDTH: rw          = value[4:0];
            REG_MONO_SPAN:   span        = value[3:0];
            REG_LEFT_SCAN:   lscan       = value[8:0];
            REG_RIGHT_SCAN:  rscan       = value[5:0];
            REG_MIN_PROM:    min_prom    = value[15:0];
            REG_BASE_LOWER:  lower_bound = $signed(value[15:0]);
            default: ;
        endcase
    endfunction

    function int at(int unsigned k);
        return ring[k % HistoryDepth];
    endfunction

    function int unsigned delay_len();
        int unsigned a;
        a = (lw > rw) ? lw : rw;
        if (span + 1 > a) a = span + 1;
        if (rscan + 1 > a) a = rscan + 1;
        return a;
    endfunction

    // Decides whether candidate c of an n-sample waveform is a peak.
    function bit judge(int unsigned c, int unsigned n, output int unsigned prom);
        int unsigned w, j, li, ri;
        int          h, lmin, rmin, base, p;
        prom = 0;
        w = (lw > rw) ? lw : rw;
        if (c < w || c + w >= n) return 0;
        h = at(c);
        for (j = c - lw; j <= c + rw; j++)
            if (j != c && at(j) > h) return 0;
        if (span > 0) begin
            if (c < span || c + span + 1 >= n) return 0;
            for (j = c - span; j < c; j++)
                if (at(j) > at(j + 1)) return 0;
            for (j = c + 1; j <= c + span; j++)
                if (at(j) < at(j + 1)) return 0;
        end
        // The left scan runs until a sample >= peak, index zero or the scan limit.
        lmin = h;
        if (c > 0) begin
            li = c - 1;
            while (li > 0 && at(li) < h && li + lscan >= c) li--;
            for (j = li; j < c; j++)
                if (at(j) < lmin && at(j) != 0) lmin = at(j);
        end
        rmin = h;
        ri = c + 1;
        while (ri < n && ri <= c + rscan && at(ri) < h) ri++;
        for (j = c + 1; j < ri; j++)
            if (at(j) < rmin && at(j) != 0) rmin = at(j);
        base = (lmin < rmin) ? lmin : rmin;
        p = h - base;
        if (base < lower_bound) p = 0;
        if (p < int'(min_prom)) return 0;
        prom = p;
        return 1;
    endfunction

    function void push_peak(logic pk, int unsigned idx, int unsigned prom, logic eow);
        peak_result_t r;
        r.is_peak         = pk;
        r.peak_index      = idx[15:0];
        r.prominence      = prom[15:0];
        r.end_of_waveform = eow;
        expected_peaks = {expected_peaks, r};
    endfunction

    // Called for every accepted input transfer.
    function void note_sample(logic signed [15:0] s, logic last);
        int unsigned a, lo, c, prom, k, st;
        a = delay_len();
        k = 0;
        if (count < MaxLength - 1) begin
            st = count;
            ring[st % HistoryDepth] = s;
            count = st + 1;
            lo = (st >= a) ? st - a : 0;
            if (!last) begin
                if (st >= a && judge(st - a, st + 1, prom)) push_peak(1, st - a, prom, 0);
                return;
            end
        end else begin
            if (!last) return;
            lo = (count >= a) ? count - a : 0;
        end
        for (c = lo; c < count && k < ResultCap; c++)
            if (judge(c, count, prom)) begin
                push_peak(1, c, prom, 0);
                k++;
            end
        if (k > 0) expected_peaks[$].end_of_waveform = 1;
        else push_peak(0, 0, 0, 1);
        count = 0;
    endfunction

    task check_result(logic pk, logic [15:0] idx, logic [15:0] prom, logic eow);
        peak_result_t e;
        if (expected_peaks.size() == 0) begin
            report("unexpected result at index", idx, -1);
            return;
        end
        e = expected_peaks.pop_front();
        if (pk !== e.is_peak) report("is_peak", pk, e.is_peak);
        if (idx !== e.peak_index) report("peak_index", idx, e.peak_index);
        if (prom !== e.prominence) report("prominence", prom, e.prominence);
        if (eow !== e.end_of_waveform) report("end_of_waveform", eow, e.end_of_waveform);
    endtask

    function int pending();
        return expected_peaks.size();
    endfunction
endclass

module tb_top;
    logic        clk = 0;
    logic        rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [AddrBits-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    wppf_in_if  in_ch ();
    wppf_out_if out_ch ();

    waveform_prominence_peak_finder_core uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    peak_scoreboard sb = new();

    // Length of the next long hold-off of the receiver; zero means none is due.
    int hold_cycles = 0;
    int quiet_cycles = 0;
    int sent = 0;

    localparam int WatchdogLimit = 400000;

    always #6 clk = ~clk;

    initial
    begin
        in_ch.valid  = 0;
        in_ch.sample = '0;
        in_ch.last   = 0;
        out_ch.ready = 0;
    end

    // The watchdog counts cycles without any transfer on either channel or the
    // register port; a hang of the block ends the run here.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver: before each result it idles for a random number of cycles, and
    // once it holds off for a long stretch so that the block stalls its input.
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (hold_cycles > 0)
            begin
                gap = hold_cycles;
                hold_cycles = 0;
            end
            else
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (gap > 0)
            begin
                out_ch.ready <= 0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
            sb.check_result(out_ch.is_peak, out_ch.peak_index, out_ch.prominence,
                            out_ch.end_of_waveform);
        end
    end

    // A register write goes through a setup phase and then an access phase.
    task write_reg(reg_index_t idx, logic [31:0] value);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= AddrBits'(4 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        sb.set_reg(idx, value);
    endtask

    // Offers one sample after an optional gap and waits for its transfer.
    // When there is no gap, valid stays high from the previous sample.
    task send_sample(logic signed [15:0] s, logic last, int gap);
        if (gap > 0)
        begin
            in_ch.valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid  <= 1;
        in_ch.sample <= s;
        in_ch.last   <= last;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sb.note_sample(s, last);
        sent++;
    endtask

    task idle_gap(output int gap);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
    endtask

    // Waits for every expected result, then lets the block settle so that
    // the registers are only written while it is idle.
    task wait_drained();
        in_ch.valid <= 0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task write_all(logic [4:0] lw, logic [4:0] rw, logic [3:0] sp, logic [8:0] ls,
                   logic [5:0] rs, logic [15:0] mp, logic [15:0] lb);
        write_reg(REG_LEFT_WIDTH, 32'(lw));
        write_reg(REG_RIGHT_WIDTH, 32'(rw));
        write_reg(REG_MONO_SPAN, 32'(sp));
        write_reg(REG_LEFT_SCAN, 32'(ls));
        write_reg(REG_RIGHT_SCAN, 32'(rs));
        write_reg(REG_MIN_PROM, 32'(mp));
        write_reg(REG_BASE_LOWER, 32'(lb));
    endtask

    // Produces one sample of a waveform. Shape 0 is full-range noise; the other
    // shapes are small-valued bumps with zeros sprinkled in, which give peaks.
    function logic signed [15:0] shape_sample(int shape, int pos, int period, int height);
        int ph;
        if (shape == 0) return 16'($urandom());
        ph = pos % period;
        if ($urandom_range(0, 15) == 0) return '0;
        if (shape == 1)
            return 16'((ph < period / 2) ? ph * height : (period - ph) * height);
        return 16'($signed(16'($urandom_range(0, 8))) - 4
                   + ((ph == period / 2) ? height * 8 : 0));
    endfunction

    task send_waveform(int len, int shape);
        int gap, period, height, i;
        period = $urandom_range(3, 24);
        height = $urandom_range(1, 400);
        for (i = 0; i < len; i++)
        begin
            idle_gap(gap);
            send_sample(shape_sample(shape, i, period, height), i == len - 1, gap);
        end
    endtask

    initial
    begin
        int len;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed part: a lone last sample, a waveform shorter than the window,
        // and then the sample extremes around a clear peak with written registers.
        send_sample(16'sd5, 1, 0);
        send_sample(16'sd1, 0, 2);
        send_sample(16'sd3, 1, 0);
        wait_drained();
        write_all(5'd2, 5'd2, 4'd0, 9'd0, 6'd0, 16'd0, 16'h8000);
        send_sample(16'sd32767, 0, 0);
        send_sample(-16'sd32768, 0, 0);
        send_sample(16'sd0, 0, 1);
        send_sample(16'sd32767, 0, 0);
        send_sample(16'sd0, 0, 0);
        send_sample(-16'sd1, 0, 0);
        send_sample(16'sd7, 0, 3);
        send_sample(16'sd7, 0, 0);
        send_sample(-16'sd32768, 0, 0);
        send_sample(16'sd100, 0, 0);
        send_sample(16'sd32767, 1, 0);
        wait_drained();

        // Rise and fall test: a peak at index four and high samples at both ends.
        write_all(5'd0, 5'd1, 4'd2, 9'd447, 6'd3, 16'd1, 16'h0000);
        send_sample(16'sd50, 0, 0);
        send_sample(16'sd10, 0, 0);
        send_sample(16'sd20, 0, 0);
        send_sample(16'sd30, 0, 0);
        send_sample(16'sd40, 0, 0);
        send_sample(16'sd30, 0, 0);
        send_sample(16'sd20, 0, 0);
        send_sample(16'sd10, 0, 0);
        send_sample(16'sd90, 1, 0);
        wait_drained();

        // Random part: a fresh register setting per waveform, the extremes
        // among them, and mostly peak-bearing waveforms with some noise.
        for (int phase = 0; sent < 195; phase++)
        begin
            case (phase % 5)
                0: write_all(5'd31, 5'd31, 4'd15, 9'd447, 6'd62, 16'd65535, 16'h7FFF);
                1: write_all(5'd0, 5'd0, 4'd0, 9'd0, 6'd0, 16'd0, 16'h8000);
                default:
                    write_all(5'($urandom_range(0, 6)), 5'($urandom_range(0, 6)),
                              4'($urandom_range(0, 3)), 9'($urandom_range(0, 447)),
                              6'($urandom_range(0, 12)), 16'($urandom_range(0, 60)),
                              ($urandom_range(0, 1) ? 16'h8000 : 16'($urandom())));
            endcase
            // In one phase the receiver holds off for a long stretch.
            if (phase == 3) hold_cycles = 3000;
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 8) : $urandom_range(10, 40);
            send_waveform(len, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 2));
            wait_drained();
        end

        repeat (100) @(posedge clk);
        if (sb.pending() != 0)
            sb.report("results still outstanding", sb.pending(), 0);
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
